FILE: design/mfd_pkg.sv
package mfd_pkg;

   // field widths of one request word and one response word
   localparam int unsigned EXP_W   = 3;
   localparam int unsigned MANT_W  = 4;
   localparam int unsigned CODE_W  = 13;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned MAG_W   = 37;

   // accepted format range
   localparam logic [EXP_W-1:0]  MIN_EXP_WIDTH  = 3'd1;
   localparam logic [EXP_W-1:0]  MAX_EXP_WIDTH  = 3'd5;
   localparam logic [MANT_W-1:0] MIN_MANT_WIDTH = 4'd1;
   localparam logic [MANT_W-1:0] MAX_MANT_WIDTH = 4'd7;

   // fraction bits of the fixed-point magnitude
   localparam logic [6:0] FRAC_BITS = 7'd21;

   typedef enum logic [KIND_W-1:0] {
      KIND_NUMBER = 3'd0,
      KIND_ZERO   = 3'd1,
      KIND_INF    = 3'd2,
      KIND_NAN    = 3'd3,
      KIND_REJECT = 3'd4
   } kind_type;

   typedef struct packed {
      logic [EXP_W-1:0]  exp_bits;
      logic [MANT_W-1:0] mant_bits;
      logic [CODE_W-1:0] code;
   } req_word_type;

   typedef struct packed {
      kind_type          kind;
      logic              sign;
      logic [MAG_W-1:0]  magnitude;
   } rsp_word_type;

endpackage

FILE: design/minifloat_decode_to_fixed.sv
// Minifloat decoder: each request word holds a right-aligned IEEE-style
// pattern (sign, exponent, mantissa) with its own exponent width (1..5) and
// mantissa width (1..7). The response word gives the class (number, signed
// zero, signed infinity, NaN or rejected format), the sign, and for numbers
// the exact magnitude as unsigned fixed point with 21 fraction bits
// (bias 2^(e-1)-1, subnormals scaled by 2^(1-bias)). One word per cycle is
// sustained while rsp_stall is low; an accepted request word passes the input
// register, then is decoded into the response register. Both
// stages move together under rsp_stall, so req_stall rises only when both
// are full.
module minifloat_decode_to_fixed (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [mfd_pkg::EXP_W-1:0]   req_exp_bits,
   input  logic [mfd_pkg::MANT_W-1:0]  req_mant_bits,
   input  logic [mfd_pkg::CODE_W-1:0]  req_code,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [mfd_pkg::KIND_W-1:0]  rsp_kind,
   output logic                        rsp_sign,
   output logic [mfd_pkg::MAG_W-1:0]   rsp_magnitude
);

   // stage 1: captured request word
   logic                  in_valid_ff;
   logic                  in_valid_in;
   mfd_pkg::req_word_type in_word_ff;

   // stage 2: decoded response word
   logic                  out_valid_ff;
   logic                  out_valid_in;
   mfd_pkg::rsp_word_type out_word_ff;
   mfd_pkg::rsp_word_type dec_word;

   logic                  out_load;
   logic                  in_load;

   // response register frees when empty or being taken
   assign out_load  = !out_valid_ff || !rsp_stall;
   // input register frees when empty or moving to the response register
   assign in_load   = !in_valid_ff || out_load;
   assign req_stall = !in_load;

   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   mfd_decode u_decode (
      .req_word (in_word_ff),
      .rsp_word (dec_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_word_ff.exp_bits  <= req_exp_bits;
         in_word_ff.mant_bits <= req_mant_bits;
         in_word_ff.code      <= req_code;
      end
      if (out_load && in_valid_ff) begin
         out_word_ff <= dec_word;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_word_ff.kind;
   assign rsp_sign      = out_word_ff.sign;
   assign rsp_magnitude = out_word_ff.magnitude;

endmodule

FILE: design/mfd_decode.sv
module mfd_decode (
   input  mfd_pkg::req_word_type req_word,
   output mfd_pkg::rsp_word_type rsp_word
);

   always_comb begin
      logic              format_ok;
      logic [2:0]        m;
      logic [6:0]        fmask;
      logic [6:0]        frac;
      logic [4:0]        emask;
      logic [12:0]       exp_word;
      logic [4:0]        expo;
      logic [3:0]        sign_pos;
      logic [12:0]       sign_word;
      logic [3:0]        bias;
      logic              subnormal;
      logic [4:0]        expo_eff;
      logic [6:0]        sh;
      logic [7:0]        sig;

      format_ok = (req_word.exp_bits >= mfd_pkg::MIN_EXP_WIDTH)
               && (req_word.exp_bits <= mfd_pkg::MAX_EXP_WIDTH)
               && (req_word.mant_bits >= mfd_pkg::MIN_MANT_WIDTH)
               && (req_word.mant_bits <= mfd_pkg::MAX_MANT_WIDTH);

      m         = req_word.mant_bits[2:0];
      fmask     = 7'((8'd1 << m) - 8'd1);
      frac      = req_word.code[6:0] & fmask;
      emask     = 5'((6'd1 << req_word.exp_bits) - 6'd1);
      exp_word  = req_word.code >> m;
      expo      = exp_word[4:0] & emask;
      sign_pos  = 4'(req_word.exp_bits) + 4'(m);
      sign_word = req_word.code >> sign_pos;
      bias      = 4'((5'd1 << (req_word.exp_bits - 3'd1)) - 5'd1);

      // subnormals use exponent 1 with no hidden bit
      subnormal = (expo == 5'd0);
      expo_eff  = subnormal ? 5'd1 : expo;
      sh        = mfd_pkg::FRAC_BITS + 7'(expo_eff) - 7'(bias) - 7'(m);
      sig       = subnormal ? {1'b0, frac} : ((8'd1 << m) | {1'b0, frac});

      rsp_word.sign      = 1'b0;
      rsp_word.magnitude = '0;
      if (!format_ok) begin
         rsp_word.kind = mfd_pkg::KIND_REJECT;
      end else begin
         rsp_word.sign = sign_word[0];
         if (expo == emask) begin
            rsp_word.kind = (frac == 7'd0) ? mfd_pkg::KIND_INF : mfd_pkg::KIND_NAN;
         end else if (subnormal && frac == 7'd0) begin
            rsp_word.kind = mfd_pkg::KIND_ZERO;
         end else begin
            rsp_word.kind      = mfd_pkg::KIND_NUMBER;
            rsp_word.magnitude = mfd_pkg::MAG_W'(sig) << sh[5:0];
         end
      end
   end

endmodule

FILE: sim/minifloat_decode_to_fixed_tb.sv
module minifloat_decode_to_fixed_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS   = 1950;
   localparam int IDLE_PERCENT   = 38;
   localparam int HOLD_CYCLES    = 60;    // long receiver hold-off
   localparam int HOLD_AT_RESULT = 1200;  // result count that starts the hold-off
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
   localparam int TAIL_CYCLES    = 8;     // two-stage pipe, plus margin

   // one pending request word plus the pacing flags that travel with it
   typedef struct {
      mfd_pkg::req_word_type word;
      bit                    steady;        // sender offers it without a gap
      bit                    drain_before;  // sender waits for all results before offering it
   } pattern_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid     = 1'b0;
   logic                       req_stall;
   logic [mfd_pkg::EXP_W-1:0]  req_exp_bits  = '0;
   logic [mfd_pkg::MANT_W-1:0] req_mant_bits = '0;
   logic [mfd_pkg::CODE_W-1:0] req_code      = '0;

   logic                       rsp_valid;
   logic                       rsp_stall     = 1'b0;
   logic [mfd_pkg::KIND_W-1:0] rsp_kind;
   logic                       rsp_sign;
   logic [mfd_pkg::MAG_W-1:0]  rsp_magnitude;

   pattern_entry_type     pending_patterns[$];
   mfd_pkg::rsp_word_type decoded_words[$];   // predicted responses, oldest first

   int words_sent      = 0;
   int results_checked = 0;
   int fail_count      = 0;
   int kind_seen[5]    = '{default: 0};
   int hold_left       = 0;
   bit hold_done       = 1'b0;
   int quiet_cycles    = 0;

   always #4 clock = ~clock;

   minifloat_decode_to_fixed u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_exp_bits  (req_exp_bits),
      .req_mant_bits (req_mant_bits),
      .req_code      (req_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_sign      (rsp_sign),
      .rsp_magnitude (rsp_magnitude)
   );

   // Predicts the response word for one pattern. Magnitude is value * 2^21:
   //   normal:    (2^m + f) << (21 + exp - bias - m)
   //   subnormal:  f        << (21 + 1 - bias - m)
   // The shift never goes negative for the legal widths, worst case is 0.
   function automatic mfd_pkg::rsp_word_type decode_minifloat(
      input mfd_pkg::req_word_type w);
      mfd_pkg::rsp_word_type r;
      int                    ew, mw, emask, frac, expo, bias, sh;
      longint unsigned       sig;
      r.kind      = mfd_pkg::KIND_REJECT;
      r.sign      = 1'b0;
      r.magnitude = '0;
      ew = int'(w.exp_bits);
      mw = int'(w.mant_bits);
      if (ew < int'(mfd_pkg::MIN_EXP_WIDTH) || ew > int'(mfd_pkg::MAX_EXP_WIDTH) ||
          mw < int'(mfd_pkg::MIN_MANT_WIDTH) || mw > int'(mfd_pkg::MAX_MANT_WIDTH))
         return r;
      emask  = (1 << ew) - 1;
      frac   = int'(w.code) & ((1 << mw) - 1);
      expo   = (int'(w.code) >> mw) & emask;
      bias   = (1 << (ew - 1)) - 1;          // 0 for a one-bit exponent
      r.sign = w.code[ew + mw];              // bits above the sign are ignored
      if (expo == emask) begin
         r.kind = (frac == 0) ? mfd_pkg::KIND_INF : mfd_pkg::KIND_NAN;
      end else if (expo == 0 && frac == 0) begin
         r.kind = mfd_pkg::KIND_ZERO;
      end else begin
         r.kind = mfd_pkg::KIND_NUMBER;
         if (expo == 0) begin
            sig = longint'(frac);
            sh  = int'(mfd_pkg::FRAC_BITS) + 1 - bias - mw;
         end else begin
            sig = longint'((1 << mw) | frac);
            sh  = int'(mfd_pkg::FRAC_BITS) + expo - bias - mw;
         end
         if (sh >= 0)
            r.magnitude = mfd_pkg::MAG_W'(sig << sh);
      end
      return r;
   endfunction

   task automatic add_pattern(input int unsigned ew, input int unsigned mw,
                              input int unsigned code, input bit steady,
                              input bit drain_before);
      pattern_entry_type p;
      p.word.exp_bits  = ew[mfd_pkg::EXP_W-1:0];
      p.word.mant_bits = mw[mfd_pkg::MANT_W-1:0];
      p.word.code      = code[mfd_pkg::CODE_W-1:0];
      p.steady         = steady;
      p.drain_before   = drain_before;
      pending_patterns.push_back(p);
   endtask

   // Sender. Records the prediction for each accepted word, then picks what
   // to present next: hold while stalled, random gaps outside the steady
   // stretch, and a full pause on words that ask for the pipe to drain first.
   always @(posedge clock) begin
      bit                    offer;
      mfd_pkg::req_word_type w;
      pattern_entry_type     p;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            w.exp_bits  = req_exp_bits;
            w.mant_bits = req_mant_bits;
            w.code      = req_code;
            decoded_words.push_back(decode_minifloat(w));
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            offer = pending_patterns.size() != 0;
            if (offer && pending_patterns[0].drain_before &&
                (req_valid || decoded_words.size() != 0))
               offer = 1'b0;
            if (offer && !pending_patterns[0].steady &&
                $urandom_range(0, 99) < IDLE_PERCENT)
               offer = 1'b0;
            if (offer) begin
               p = pending_patterns.pop_front();
               req_exp_bits  <= p.word.exp_bits;
               req_mant_bits <= p.word.mant_bits;
               req_code      <= p.word.code;
            end
            req_valid <= offer;
         end
      end
   end

   // Receiver. Checks each accepted response word against the oldest
   // prediction, then picks next cycle's stall: a single long hold-off to
   // back the pipe up into req_stall, a no-stall stretch, else random stalls.
   always @(posedge clock) begin
      mfd_pkg::rsp_word_type want;
      bit                    stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_words.size() == 0) begin
               $error("response word with nothing outstanding: kind %0d sign %0d mag %0d",
                      rsp_kind, rsp_sign, rsp_magnitude);
               fail_count++;
            end else begin
               want = decoded_words.pop_front();
               kind_seen[want.kind]++;
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_sign !== want.sign) begin
                  $error("sign: expected %0d, got %0d", want.sign, rsp_sign);
                  fail_count++;
               end
               if (rsp_magnitude !== want.magnitude) begin
                  $error("magnitude: expected %0d, got %0d", want.magnitude, rsp_magnitude);
                  fail_count++;
               end
            end
            results_checked++;
         end
         if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (!hold_done && results_checked >= HOLD_AT_RESULT) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            stall_next = 1'b1;
         end else if (results_checked >= 300 && results_checked < 550) begin
            stall_next = 1'b0;
         end else begin
            stall_next = $urandom_range(0, 99) < IDLE_PERCENT;
         end
         rsp_stall <= stall_next;
      end
   end

   // Watchdog: any stretch with no word moving on either side is a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles, %0d words outstanding",
                  quiet_cycles, decoded_words.size());
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned                ew, mw;
      logic [mfd_pkg::CODE_W-1:0] code, field_mask;

      // rejected formats: widths of zero and past the top, mostly all code bits set
      add_pattern(0, 3, 13'h1FFF, 1'b0, 1'b0);
      add_pattern(6, 3, 13'h1FFF, 1'b0, 1'b0);
      add_pattern(7, 15, 13'h1FFF, 1'b0, 1'b0);
      add_pattern(3, 0, 13'h1FFF, 1'b0, 1'b0);
      add_pattern(3, 8, 13'h1FFF, 1'b0, 1'b0);
      add_pattern(4, 15, 13'h0000, 1'b0, 1'b0);
      // one-bit exponent, bias 0: every pattern (zeros, subnormals, inf, NaN)
      for (int c = 0; c < 8; c++)
         add_pattern(1, 1, c, 1'b0, 1'b0);
      // widest format: largest normal both signs, subnormal ends, specials
      add_pattern(5, 7, 13'h0F7F, 1'b0, 1'b0);
      add_pattern(5, 7, 13'h1F7F, 1'b0, 1'b0);
      add_pattern(5, 7, 13'h007F, 1'b0, 1'b0);
      add_pattern(5, 7, 13'h0001, 1'b0, 1'b0);
      add_pattern(5, 7, 13'h1000, 1'b0, 1'b0);
      add_pattern(5, 7, 13'h1F80, 1'b0, 1'b0);
      add_pattern(5, 7, 13'h0FC1, 1'b0, 1'b0);
      // 1.0 in a mid format, and junk above the sign bit
      add_pattern(3, 4, 13'h0030, 1'b0, 1'b0);
      add_pattern(2, 1, 13'h1FF5, 1'b0, 1'b0);

      // Random words, mostly legal formats with the exponent field often
      // forced to all zeros or all ones so specials and subnormals show up.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if ($urandom_range(0, 99) < 12) begin
            ew   = $urandom_range(0, 7);
            mw   = $urandom_range(0, 15);
            code = mfd_pkg::CODE_W'($urandom);
         end else begin
            ew         = $urandom_range(1, 5);
            mw         = $urandom_range(1, 7);
            code       = mfd_pkg::CODE_W'($urandom_range(0, 8191));
            field_mask = mfd_pkg::CODE_W'(((1 << ew) - 1) << mw);
            case ($urandom_range(0, 3))
               0: code = code & ~field_mask;
               1: code = code | field_mask;
               default: ;
            endcase
            if ($urandom_range(0, 3) == 0)
               code = code & ~mfd_pkg::CODE_W'((1 << mw) - 1);
         end
         add_pattern(ew, mw, code, i >= 600 && i < 900, i == 0 || i == 1000);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_patterns.size() != 0 || req_valid || decoded_words.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d words, checked %0d: %0d numbers, %0d zeros, %0d infinities, %0d NaNs,",
               words_sent, results_checked, kind_seen[mfd_pkg::KIND_NUMBER],
               kind_seen[mfd_pkg::KIND_ZERO], kind_seen[mfd_pkg::KIND_INF],
               kind_seen[mfd_pkg::KIND_NAN]);
      $display("%0d rejected formats; %0d mismatches", kind_seen[mfd_pkg::KIND_REJECT],
               fail_count);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
